// ===== hw/rtl/lspg_pkg.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern generator package
// Pattern codes, pattern constants and elaboration-time table builders.
// ----------------------------------------------------------------------------
package lspg_pkg;

  // Pattern select codes
  typedef enum logic [1:0] {
    ModeRainbow = 2'd0,
    ModeWave    = 2'd1,
    ModeNight   = 2'd2,
    ModeGrey    = 2'd3
  } pattern_mode_e;

  localparam pattern_mode_e ModeReset = ModeWave;

  // Strip and sine defaults
  localparam int unsigned StripPixels        = 256;
  localparam int unsigned DefaultSineFracBits = 14;

  // Periods of the patterns
  localparam int unsigned RainbowPeriod = 92;
  localparam int unsigned EnvPeriod     = 420;
  localparam int unsigned WavePeriod    = 64;
  localparam int unsigned GreyPeriod    = 100;
  localparam int unsigned BandWidth     = 13;

  // Phase offsets of the three wave channels
  localparam logic [5:0] WaveOffsetR = 6'd18;
  localparam logic [5:0] WaveOffsetG = 6'd48;
  localparam logic [5:0] WaveOffsetB = 6'(80 - WavePeriod);

  // Channel base and swing levels
  localparam logic [7:0] WaveBase  = 8'd128;
  localparam logic [6:0] WaveAmp   = 7'd127;
  localparam logic [7:0] NightRBase = 8'd70;
  localparam logic [6:0] NightRAmp  = 7'd50;
  localparam logic [7:0] NightBBase = 8'd128;
  localparam logic [6:0] NightBAmp  = 7'd88;

  // Rainbow band colors, GRB order, last band dark
  localparam logic [23:0] RainbowGrb [8] = '{
    24'h00FF00, 24'h7FFF00, 24'hFFFF00, 24'hFF0000,
    24'h0000FF, 24'h004B82, 24'h82EEEE, 24'h000000
  };

  // Angle constants in Q30
  localparam longint unsigned PiQ30     = 64'd3373259426;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint          OneQ30    = 64'sd1073741824;

  // Angle divisors: 100 times the period, matching the 6.28 scale
  localparam longint unsigned EnvAngleDiv  = 100 * EnvPeriod;
  localparam longint unsigned WaveAngleDiv = 100 * WavePeriod;

  // Modulus selectors for the byte residue tables
  localparam int unsigned SelRainbow = 0;
  localparam int unsigned SelEnv     = 1;
  localparam int unsigned SelGrey    = 2;

  // Residue of one byte placed at byte lane k, for one of the moduli
  function automatic int unsigned byte_residue(input int unsigned b, input int unsigned k,
                                               input int unsigned sel);
    longint unsigned v;
    longint unsigned r;
    v = longint'(b) << (8 * k);
    case (sel)
      SelRainbow: r = v % RainbowPeriod;
      SelEnv:     r = v % EnvPeriod;
      default:    r = v % GreyPeriod;
    endcase
    return int'(r);
  endfunction

  // Rainbow color for a position within the period
  function automatic logic [23:0] rainbow_word(input int unsigned x);
    int unsigned band;
    band = (RainbowPeriod - x) / BandWidth;
    return RainbowGrb[band[2:0]];
  endfunction

  // Sine table entry, signed fixed point with frac fraction bits
  function automatic longint sine_q(input int unsigned pos, input logic env,
                                    input int unsigned frac);
    longint unsigned num;
    longint unsigned phi;
    longint unsigned phi2;
    longint unsigned term;
    longint          acc;
    longint          r;
    logic            neg;
    num = env ? longint'(EnvPeriod - pos) : longint'(WavePeriod - pos);
    num = (num * 628) << 30;
    phi = env ? num / EnvAngleDiv : num / WaveAngleDiv;
    neg = 1'b1;
    if (phi >= PiQ30) begin
      phi = phi - PiQ30;
      neg = 1'b0;
    end
    if (phi > HalfPiQ30) begin
      phi = PiQ30 - phi;
    end
    phi2 = (phi * phi) >> 30;
    term = phi;
    acc  = longint'(phi);
    // Taylor terms up to the 13th power
    term = ((term * phi2) >> 30) / 6;
    acc  = acc - longint'(term);
    term = ((term * phi2) >> 30) / 20;
    acc  = acc + longint'(term);
    term = ((term * phi2) >> 30) / 42;
    acc  = acc - longint'(term);
    term = ((term * phi2) >> 30) / 72;
    acc  = acc + longint'(term);
    term = ((term * phi2) >> 30) / 110;
    acc  = acc - longint'(term);
    term = ((term * phi2) >> 30) / 156;
    acc  = acc + longint'(term);
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > OneQ30) begin
      acc = OneQ30;
    end
    r = (acc + (64'sd1 << (29 - frac))) >>> (30 - frac);
    return neg ? -r : r;
  endfunction

endpackage

// ===== hw/rtl/led_strip_pattern_generator_top.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern generator
// Six-stage pipeline that turns a pixel index and frame time into a GRB word.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with pixel_index_i and frame_time_i; a beat is taken at every
//   rising edge where start is high and busy is low. busy stays low, so one
//   pixel may be issued in every cycle.
//   The color word appears on color_word_o for one cycle with pixel_valid_o
//   high, once the beat has run through the register stages listed below,
//   and is taken at the edge that ends that cycle; results leave in issue order.
//   Throughput is one pixel per clock; the pipeline has six register stages:
//   position add, byte residue sum, modulo fold, table read, channel mix,
//   and the envelope multiply feeding the output register.
//   cfg_we_i writes cfg_wdata_i to the pattern select at once; write it only
//   while no pixel is in flight, since pixels carry the select they saw.
//   Reset clears the pipeline valid bits and sets the color wave pattern.
//   The receiver cannot stall: every result beat is taken in its cycle.
// ----------------------------------------------------------------------------
module led_strip_pattern_generator_top #(
  parameter int unsigned SINE_FRACTION_BITS = lspg_pkg::DefaultSineFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  pixel_index_i,
  input  logic [31:0] frame_time_i,
  output logic        pixel_valid_o,
  output logic [23:0] color_word_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i
);
  import lspg_pkg::*;

  localparam int unsigned F      = SINE_FRACTION_BITS;
  localparam int unsigned SW     = F + 2;   // signed sine sample
  localparam int unsigned EW     = F + 2;   // unsigned envelope
  localparam int unsigned CW     = F + 8;   // unsigned channel level
  localparam int unsigned PW     = CW + EW; // product
  localparam int unsigned Stages = 6;

  // Constant tables
  logic signed [SW-1:0] env_rom  [EnvPeriod];
  logic signed [SW-1:0] wave_rom [WavePeriod];
  logic [23:0]          rainbow_lut [RainbowPeriod];
  logic [6:0]           res92  [4][256];
  logic [8:0]           res420 [4][256];
  logic [6:0]           res100 [4][256];

  for (genvar g = 0; g < EnvPeriod; g++) begin : g_env_rom
    localparam logic signed [SW-1:0] Entry = SW'(sine_q(g, 1'b1, F));
    assign env_rom[g] = Entry;
  end
  for (genvar g = 0; g < WavePeriod; g++) begin : g_wave_rom
    localparam logic signed [SW-1:0] Entry = SW'(sine_q(g, 1'b0, F));
    assign wave_rom[g] = Entry;
  end
  for (genvar g = 0; g < RainbowPeriod; g++) begin : g_rainbow
    localparam logic [23:0] Entry = rainbow_word(g);
    assign rainbow_lut[g] = Entry;
  end
  for (genvar k = 0; k < 4; k++) begin : g_lane
    for (genvar b = 0; b < 256; b++) begin : g_byte
      localparam logic [6:0] Res92  = 7'(byte_residue(b, k, SelRainbow));
      localparam logic [8:0] Res420 = 9'(byte_residue(b, k, SelEnv));
      localparam logic [6:0] Res100 = 7'(byte_residue(b, k, SelGrey));
      assign res92[k][b]  = Res92;
      assign res420[k][b] = Res420;
      assign res100[k][b] = Res100;
    end
  end

  // Channel level: base scaled to one plus swing times sine
  function automatic logic [CW-1:0] mix(input logic [7:0] base, input logic [6:0] amp,
                                        input logic signed [SW-1:0] s);
    logic signed [CW+1:0] acc;
    acc = $signed({2'b00, base, {F{1'b0}}}) + $signed({1'b0, amp}) * s;
    return acc[CW-1:0];
  endfunction

  logic                 accept;
  logic [Stages-1:0]    vld_q, vld_d;
  pattern_mode_e        mode_q;

  // Stage 1
  logic [31:0]   pos1_q;
  logic [31:0]   t1_q;
  logic [7:0]    idx1_q;
  logic          out1_q;
  pattern_mode_e mode1_q;
  // Stage 2
  logic [8:0]    sum92_q, sum100_q;
  logic [10:0]   sum420_q;
  logic [5:0]    p2_q;
  logic [7:0]    idx2_q;
  logic          out2_q;
  pattern_mode_e mode2_q;
  // Stage 3
  logic [6:0]    x92_q, tm100_q;
  logic [8:0]    x420_q;
  logic [5:0]    w1_q, w2_q, w3_q;
  logic [7:0]    idx3_q;
  logic          out3_q;
  pattern_mode_e mode3_q;
  logic [8:0]    red92, red100;
  logic [10:0]   red420;
  // Stage 4
  logic [EW-1:0]        env4_q;
  logic signed [SW-1:0] s1_q, s2_q, s3_q;
  logic [23:0]          rgb4_q;
  logic [6:0]           lvl4_q;
  logic                 out4_q;
  pattern_mode_e        mode4_q;
  logic [8:0]           gsum, gred;
  // Stage 5
  logic [CW-1:0]  cr_q, cg_q, cb_q;
  logic [CW-1:0]  cr_d, cg_d, cb_d;
  logic [EW-1:0]  env5_q;
  logic [23:0]    rgb5_q;
  logic [6:0]     lvl5_q;
  logic           out5_q;
  pattern_mode_e  mode5_q;
  // Stage 6
  logic [PW-1:0]  pr, pg, pb;
  logic [23:0]    grb_d, grb_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Hold the pattern select and advance the valid bits
  assign vld_d = {vld_q[Stages-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      mode_q <= ModeReset;
    end else begin
      vld_q <= vld_d;
      if (cfg_we_i) begin
        mode_q <= pattern_mode_e'(cfg_wdata_i);
      end
    end
  end

  // Fold byte residue sums below twice the modulus
  always_comb begin
    red92  = (sum92_q >= 9'(2 * RainbowPeriod)) ? sum92_q - 9'(2 * RainbowPeriod) : sum92_q;
    red420 = (sum420_q >= 11'(2 * EnvPeriod)) ? sum420_q - 11'(2 * EnvPeriod) : sum420_q;
    red100 = (sum100_q >= 9'(2 * GreyPeriod)) ? sum100_q - 9'(2 * GreyPeriod) : sum100_q;
  end

  // Grey level: time residue plus index, folded below twice the period
  always_comb begin
    gsum = 9'(tm100_q) + 9'(idx3_q);
    gred = (gsum >= 9'(2 * GreyPeriod)) ? gsum - 9'(2 * GreyPeriod) : gsum;
  end

  // Select channel levels for the pattern
  always_comb begin
    cr_d = '0;
    cg_d = '0;
    cb_d = '0;
    case (mode4_q)
      ModeWave: begin
        cr_d = mix(WaveBase, WaveAmp, s1_q);
        cg_d = mix(WaveBase, WaveAmp, s2_q);
        cb_d = mix(WaveBase, WaveAmp, s3_q);
      end
      ModeNight: begin
        cr_d = mix(NightRBase, NightRAmp, s1_q);
        cb_d = mix(NightBBase, NightBAmp, s1_q);
      end
      default: begin
        cr_d = '0;
      end
    endcase
  end

  // Apply the envelope and assemble the word
  assign pr = PW'(cr_q) * PW'(env5_q);
  assign pg = PW'(cg_q) * PW'(env5_q);
  assign pb = PW'(cb_q) * PW'(env5_q);

  always_comb begin
    unique case (mode5_q)
      ModeRainbow: grb_d = rgb5_q;
      ModeWave:    grb_d = {pg[2*F+8:2*F+1], pr[2*F+8:2*F+1], pb[2*F+8:2*F+1]};
      ModeNight:   grb_d = {8'd0, pr[2*F+9:2*F+2], pb[2*F+9:2*F+2]};
      ModeGrey:    grb_d = {3{{1'b0, lvl5_q}}};
      default:     grb_d = '0;
    endcase
    if (out5_q) begin
      grb_d = '0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    // Stage 1: position along the animation
    pos1_q  <= {1'b0, frame_time_i[31:1]} + 32'(pixel_index_i);
    t1_q    <= frame_time_i;
    idx1_q  <= pixel_index_i;
    out1_q  <= 32'(pixel_index_i) >= 32'(StripPixels);
    mode1_q <= mode_q;
    // Stage 2: sum byte residues
    sum92_q  <= 9'(res92[0][pos1_q[7:0]]) + 9'(res92[1][pos1_q[15:8]])
              + 9'(res92[2][pos1_q[23:16]]) + 9'(res92[3][pos1_q[31:24]]);
    sum420_q <= 11'(res420[0][pos1_q[7:0]]) + 11'(res420[1][pos1_q[15:8]])
              + 11'(res420[2][pos1_q[23:16]]) + 11'(res420[3][pos1_q[31:24]]);
    sum100_q <= 9'(res100[0][t1_q[7:0]]) + 9'(res100[1][t1_q[15:8]])
              + 9'(res100[2][t1_q[23:16]]) + 9'(res100[3][t1_q[31:24]]);
    p2_q    <= pos1_q[5:0];
    idx2_q  <= idx1_q;
    out2_q  <= out1_q;
    mode2_q <= mode1_q;
    // Stage 3: final modulo fold and wave phases
    x92_q   <= 7'((red92 >= 9'(RainbowPeriod)) ? red92 - 9'(RainbowPeriod) : red92);
    x420_q  <= 9'((red420 >= 11'(EnvPeriod)) ? red420 - 11'(EnvPeriod) : red420);
    tm100_q <= 7'((red100 >= 9'(GreyPeriod)) ? red100 - 9'(GreyPeriod) : red100);
    w1_q    <= p2_q + WaveOffsetR;
    w2_q    <= p2_q + WaveOffsetG;
    w3_q    <= p2_q + WaveOffsetB;
    idx3_q  <= idx2_q;
    out3_q  <= out2_q;
    mode3_q <= mode2_q;
    // Stage 4: table reads
    env4_q  <= EW'(env_rom[x420_q]) + (EW'(1) << F);
    s1_q    <= wave_rom[w1_q];
    s2_q    <= wave_rom[w2_q];
    s3_q    <= wave_rom[w3_q];
    rgb4_q  <= rainbow_lut[x92_q];
    lvl4_q  <= 7'((gred >= 9'(GreyPeriod)) ? gred - 9'(GreyPeriod) : gred);
    out4_q  <= out3_q;
    mode4_q <= mode3_q;
    // Stage 5: channel levels
    cr_q    <= cr_d;
    cg_q    <= cg_d;
    cb_q    <= cb_d;
    env5_q  <= env4_q;
    rgb5_q  <= rgb4_q;
    lvl5_q  <= lvl4_q;
    out5_q  <= out4_q;
    mode5_q <= mode4_q;
    // Stage 6: output word
    grb_q   <= grb_d;
  end

  assign pixel_valid_o = vld_q[Stages-1];
  assign color_word_o  = grb_q;

  // Checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o |-> $past(start, 6) && !$past(busy, 6))
    else $error("result beat without a matching input beat");

  a_beyond_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o && (32'($past(pixel_index_i, 6)) >= 32'(StripPixels))
      |-> color_word_o == 24'd0)
    else $error("pixel beyond strip not dark");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (x92_q < 7'(RainbowPeriod)) && (x420_q < 9'(EnvPeriod))
                 && (tm100_q < 7'(GreyPeriod)))
    else $error("modulo fold out of range");

  a_grey_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o && $past(mode5_q) == ModeGrey
      |-> color_word_o[23:16] == color_word_o[15:8]
          && color_word_o[15:8] == color_word_o[7:0])
    else $error("grey ramp channels differ");

  a_night_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o && $past(mode5_q) == ModeNight |-> color_word_o[23:16] == 8'd0)
    else $error("night wave drives green");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED strip pattern generator testbench
// Drives pixel index and frame time beats through all four patterns and
// checks every color word against a behavioral predictor. The predictor
// builds its own sine tables at startup and follows the block's pattern
// select as it is written between phases. The sender pauses at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lspg_pkg::*;

  localparam int unsigned FracBits   = DefaultSineFracBits;
  localparam int unsigned DrainLimit = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [7:0]  pixel_index_i;
  logic [31:0] frame_time_i;
  logic        pixel_valid_o;
  logic [23:0] color_word_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;

  // Predictor state
  logic [23:0]   band_grb [8] = '{
    24'h00FF00, 24'h7FFF00, 24'hFFFF00, 24'hFF0000,
    24'h0000FF, 24'h004B82, 24'h82EEEE, 24'h000000
  };
  longint        env_sine [420];
  longint        wave_sine [64];
  pattern_mode_e mode_shadow;
  logic [23:0]   grb_expected [$];
  logic [23:0]   grb_front;

  // Run bookkeeping
  int unsigned error_count;
  int unsigned beats_per_mode [4];
  int unsigned gap_pct;
  bit          gaps_on;

  led_strip_pattern_generator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .pixel_index_i (pixel_index_i),
    .frame_time_i  (frame_time_i),
    .pixel_valid_o (pixel_valid_o),
    .color_word_o  (color_word_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Signed sine sample at position pos of the given period, Q30 Taylor series
  function automatic longint sine_entry(input int unsigned pos, input int unsigned period);
    longint unsigned num;
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned term;
    longint          sum;
    longint          r;
    bit              flip;
    num  = 64'(period - pos);
    num  = (num * 628) << 30;
    ang  = num / (100 * period);
    flip = 1'b1;
    if (ang >= PiQ30) begin
      ang  = ang - PiQ30;
      flip = 1'b0;
    end
    if (ang > HalfPiQ30) begin
      ang = PiQ30 - ang;
    end
    ang2 = (ang * ang) >> 30;
    term = ang;
    sum  = longint'(ang);
    for (int unsigned k = 1; k <= 6; k++) begin
      term = ((term * ang2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > OneQ30) begin
      sum = OneQ30;
    end
    r = (sum + (64'sd1 << (29 - FracBits))) >>> (30 - FracBits);
    return flip ? -r : r;
  endfunction

  // Scale one channel: (base + amp * sine) times envelope, keep 8 bits
  function automatic logic [7:0] mix_channel(input longint base, input longint amp,
                                             input longint s, input longint env,
                                             input int unsigned shift);
    longint unsigned prod;
    prod = $unsigned(base * (64'sd1 << FracBits) + amp * s) * $unsigned(env);
    prod = prod >> shift;
    return prod[7:0];
  endfunction

  // Color word of one pixel under the given pattern
  function automatic logic [23:0] predict_grb(input pattern_mode_e mode,
                                              input logic [7:0] idx,
                                              input logic [31:0] t);
    longint unsigned pos;
    longint          env;
    longint          s_r;
    longint          s_g;
    longint          s_b;
    int unsigned     x;
    logic [7:0]      lvl;
    pos = 64'(idx);
    pos = pos + 64'(t >> 1);
    env = env_sine[pos % EnvPeriod] + (64'sd1 << FracBits);
    s_r = wave_sine[(pos + 18) % WavePeriod];
    s_g = wave_sine[(pos + 48) % WavePeriod];
    s_b = wave_sine[(pos + 80) % WavePeriod];
    case (mode)
      ModeRainbow: begin
        x = 32'(pos % RainbowPeriod);
        predict_grb = band_grb[((RainbowPeriod - x) / BandWidth) & 7];
      end
      ModeWave: begin
        predict_grb = {mix_channel(128, 127, s_g, env, 2 * FracBits + 1),
                       mix_channel(128, 127, s_r, env, 2 * FracBits + 1),
                       mix_channel(128, 127, s_b, env, 2 * FracBits + 1)};
      end
      ModeNight: begin
        predict_grb = {8'h00,
                       mix_channel(70, 50, s_r, env, 2 * FracBits + 2),
                       mix_channel(128, 88, s_r, env, 2 * FracBits + 2)};
      end
      default: begin
        // grey ramp runs on the raw frame time
        lvl = 8'(((t % GreyPeriod) + idx) % GreyPeriod);
        predict_grb = {lvl, lvl, lvl};
      end
    endcase
  endfunction

  // Check each result beat, then predict each accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pixel_valid_o) begin
        if (grb_expected.size() == 0) begin
          $display("%0t: unexpected pixel beat, expected none, got %06h",
                   $time, color_word_o);
          error_count++;
        end else begin
          grb_front = grb_expected.pop_front();
          if (color_word_o !== grb_front) begin
            $display("%0t: color word mismatch, expected %06h, got %06h",
                     $time, grb_front, color_word_o);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        grb_expected.push_back(predict_grb(mode_shadow, pixel_index_i, frame_time_i));
        beats_per_mode[mode_shadow]++;
      end
    end
  end

  // Offer one input beat, after an optional random pause; return at acceptance
  task automatic send_pixel(input logic [7:0] idx, input logic [31:0] t);
    if (gaps_on && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    start         <= 1'b1;
    pixel_index_i <= idx;
    frame_time_i  <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start and wait for every predicted beat, then let the pipe settle
  task automatic drain_pipeline();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    while (grb_expected.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Write the pattern select while the pipeline is empty
  task automatic set_pattern(input pattern_mode_e mode);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_shadow = mode;
  endtask

  // Pattern after reset is the color wave
  task automatic test_reset_pattern();
    send_pixel(8'd0, 32'd0);
    send_pixel(8'd255, 32'hFFFF_FFFF);
    send_pixel(8'h5A, 32'h0000_01A4);
  endtask

  // Field extremes, dark band and grey timing
  task automatic test_directed_cases();
    set_pattern(ModeRainbow);
    send_pixel(8'd0, 32'd0);
    send_pixel(8'd1, 32'd0);
    send_pixel(8'd0, 32'd2);
    send_pixel(8'd91, 32'd0);
    send_pixel(8'd0, 32'd184);
    send_pixel(8'd13, 32'd0);
    send_pixel(8'd255, 32'hFFFF_FFFF);
    set_pattern(ModeNight);
    send_pixel(8'd0, 32'd0);
    send_pixel(8'd255, 32'hFFFF_FFFF);
    send_pixel(8'd46, 32'd0);
    set_pattern(ModeGrey);
    send_pixel(8'd0, 32'd0);
    send_pixel(8'd0, 32'd1);
    send_pixel(8'd99, 32'd0);
    send_pixel(8'd1, 32'd99);
    send_pixel(8'd255, 32'hFFFF_FFFF);
  endtask

  // Random pixels under one pattern, pause rate reshuffled every 40 beats
  task automatic test_random_pattern(input pattern_mode_e mode, input int unsigned count);
    logic [7:0]  idx;
    logic [31:0] t;
    set_pattern(mode);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 5;
          2:       gap_pct = 20;
          default: gap_pct = 45;
        endcase
      end
      case ($urandom_range(0, 7))
        0:       idx = 8'd0;
        1:       idx = 8'd255;
        default: idx = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0:       t = $urandom_range(0, 2000);
        1:       t = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        default: t = $urandom;
      endcase
      send_pixel(idx, t);
    end
  endtask

  // Main sequence
  initial begin
    start         <= 1'b0;
    pixel_index_i <= '0;
    frame_time_i  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= ModeRainbow;
    rst_ni        <= 1'b0;
    gaps_on       = 1'b0;
    gap_pct       = 0;
    mode_shadow   = ModeReset;
    for (int unsigned p = 0; p < EnvPeriod; p++) begin
      env_sine[p] = sine_entry(p, EnvPeriod);
    end
    for (int unsigned p = 0; p < WavePeriod; p++) begin
      wave_sine[p] = sine_entry(p, WavePeriod);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_pattern();
    test_directed_cases();
    gaps_on = 1'b1;
    test_random_pattern(ModeRainbow, 400);
    test_random_pattern(ModeGrey, 400);
    test_random_pattern(ModeNight, 400);
    test_random_pattern(ModeWave, 400);
    // back-to-back stream at the end
    gaps_on = 1'b0;
    test_random_pattern(ModeRainbow, 100);
    drain_pipeline();

    if (grb_expected.size() != 0) begin
      $display("%0t: %0d pixel beats never arrived, expected %06h first, got none",
               $time, grb_expected.size(), grb_expected[0]);
      error_count++;
    end
    $display("Pixels checked per pattern: rainbow %0d, wave %0d, night %0d, grey %0d",
             beats_per_mode[ModeRainbow], beats_per_mode[ModeWave],
             beats_per_mode[ModeNight], beats_per_mode[ModeGrey]);
    $display("Pattern select rewritten between phases; %0d errors seen", error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
